@@ src/lcdseq_pkg.sv @@
// Package with the shared types, constants and helper functions of the LCD write sequencer.
package lcdseq_pkg;

	localparam int CntW   = 16;
	localparam int CfgW   = 16;
	localparam int CfgIdxW = 3;
	localparam int QDepth = 2;
	localparam int QPtrW  = 1;
	localparam int QCntW  = 2;

	localparam logic [7:0] WakeByte  = 8'h20;
	localparam logic [7:0] ClearByte = 8'h01;

	localparam logic [2:0] StepNone  = 3'd0;
	localparam logic [2:0] StepWake  = 3'd1;
	localparam logic [2:0] StepClear = 3'd5;
	localparam logic [2:0] StepEntry = 3'd6;

	localparam logic [7:0]  RstEnablePulse  = 8'd4;
	localparam logic [15:0] RstShortWait    = 16'd40;
	localparam logic [15:0] RstLongWait     = 16'd100;
	localparam logic [15:0] RstClearWait    = 16'd2000;
	localparam logic [15:0] RstInitFinal    = 16'd50000;
	localparam logic [7:0]  RstFunctionSet  = 8'h2C;
	localparam logic [7:0]  RstDisplayCtrl  = 8'h0C;
	localparam logic [7:0]  RstEntryMode    = 8'h06;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_INSTR = 2'd1,
		OP_CHAR  = 2'd2,
		OP_INIT  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		CFG_ENABLE_PULSE    = 3'd0,
		CFG_SHORT_WAIT      = 3'd1,
		CFG_LONG_WAIT       = 3'd2,
		CFG_CLEAR_WAIT      = 3'd3,
		CFG_INIT_FINAL_WAIT = 3'd4,
		CFG_FUNCTION_SET    = 3'd5,
		CFG_DISPLAY_CONTROL = 3'd6,
		CFG_ENTRY_MODE      = 3'd7
	} cfg_idx_t;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_PULSE = 2'd1,
		PH_GAP   = 2'd2,
		PH_WAIT  = 2'd3
	} phase_t;

	typedef struct packed {
		logic       is_tick;
		logic       start_init;
		logic       start_rs;
		logic [7:0] start_byte;
	} item_t;

	function automatic logic [CntW-1:0] load_count(input logic [CfgW-1:0] v);
		logic [32:0] maxv;
		logic [32:0] w;
		maxv = (33'd1 << CntW) - 33'd1;
		w = {{(33-CfgW){1'b0}}, v};
		if (w == 33'd0) begin
			w = 33'd1;
		end
		if (w > maxv) begin
			w = maxv;
		end
		return w[CntW-1:0];
	endfunction

	function automatic logic [7:0] init_byte(input logic [2:0] step, input logic [7:0] fs,
			input logic [7:0] dc, input logic [7:0] em);
		logic [7:0] b;
		case (step)
			3'd1:       b = WakeByte;
			3'd2, 3'd3: b = fs;
			3'd4:       b = dc;
			3'd5:       b = ClearByte;
			default:    b = em;
		endcase
		return b;
	endfunction

endpackage

@@ src/lcdseq_front.sv @@
// Front end: accepts input beats and classifies them into tick or command start items.
module lcdseq_front import lcdseq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] operation,
	input  logic [7:0] data_byte,
	output logic       push_valid,
	input  logic       push_ready,
	output item_t      push_item
);

	logic  valid_s1;
	item_t item_s1;
	item_t item_d;
	logic  take;

	assign in_ready   = !valid_s1 || push_ready;
	assign take       = in_valid && in_ready;
	assign push_valid = valid_s1;
	assign push_item  = item_s1;

	always_comb begin
		item_d = '0;
		case (op_t'(operation))
			OP_TICK: begin
				item_d.is_tick = 1'b1;
			end
			OP_INSTR: begin
				item_d.start_byte = data_byte;
			end
			OP_CHAR: begin
				item_d.start_rs   = 1'b1;
				item_d.start_byte = data_byte;
			end
			OP_INIT: begin
				item_d.start_init = 1'b1;
				item_d.start_byte = WakeByte;
			end
			default: begin
				item_d.is_tick = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= item_d;
		end
	end

endmodule

@@ src/lcdseq_queue.sv @@
// Short first-in first-out queue of classified items between the front and back ends.
module lcdseq_queue import lcdseq_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_valid,
	output logic  push_ready,
	input  item_t push_item,
	output logic  pop_valid,
	input  logic  pop_ready,
	output item_t pop_item
);

	item_t            mem_q [QDepth];
	logic [QPtrW-1:0] wr_ptr_q;
	logic [QPtrW-1:0] rd_ptr_q;
	logic [QCntW-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (cnt_q != QCntW'(QDepth));
	assign pop_valid  = (cnt_q != '0);
	assign pop_item   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPtrW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPtrW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + QCntW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - QCntW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCntW'(QDepth)) else $error("queue fill count out of range");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == QCntW'(QDepth)) |-> !do_push) else $error("push into full queue");

endmodule

@@ src/lcdseq_back.sv @@
// Back end: configuration registers, write sequencer state and the registered result beat.
module lcdseq_back import lcdseq_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wen,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [CfgW-1:0]    cfg_data,
	input  logic               pop_valid,
	output logic               pop_ready,
	input  item_t              pop_item,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               rs_pin,
	output logic               enable_pin,
	output logic [3:0]         data_nibble,
	output logic               busy_res,
	output logic               accepted
);

	logic [7:0]  pulse_q;
	logic [15:0] short_q;
	logic [15:0] long_q;
	logic [15:0] clear_q;
	logic [15:0] final_q;
	logic [7:0]  fs_q;
	logic [7:0]  dc_q;
	logic [7:0]  em_q;

	phase_t          phase_q, phase_d;
	logic [2:0]      step_q, step_d;
	logic [CntW-1:0] cnt_q, cnt_d;
	logic [7:0]      byte_q, byte_d;
	logic            rs_q, rs_d;
	logic            low_q, low_d;
	logic            acc_d;
	logic [15:0]     wait_len;
	logic            pop;

	logic       out_valid_q;
	logic       rs_pin_q, en_pin_q, busy_pin_q, acc_pin_q;
	logic [3:0] nib_q;
	logic       en_d, busy_d;
	logic [3:0] nib_d;

	assign pop_ready = !out_valid_q || out_ready;
	assign pop       = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_q <= RstEnablePulse;
			short_q <= RstShortWait;
			long_q  <= RstLongWait;
			clear_q <= RstClearWait;
			final_q <= RstInitFinal;
			fs_q    <= RstFunctionSet;
			dc_q    <= RstDisplayCtrl;
			em_q    <= RstEntryMode;
		end else if (cfg_wen) begin
			case (cfg_idx_t'(cfg_index))
				CFG_ENABLE_PULSE:    pulse_q <= cfg_data[7:0];
				CFG_SHORT_WAIT:      short_q <= cfg_data;
				CFG_LONG_WAIT:       long_q  <= cfg_data;
				CFG_CLEAR_WAIT:      clear_q <= cfg_data;
				CFG_INIT_FINAL_WAIT: final_q <= cfg_data;
				CFG_FUNCTION_SET:    fs_q    <= cfg_data[7:0];
				CFG_DISPLAY_CONTROL: dc_q    <= cfg_data[7:0];
				CFG_ENTRY_MODE:      em_q    <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (step_q != StepNone) begin
			if (step_q == StepClear) begin
				wait_len = clear_q;
			end else if (step_q >= StepEntry) begin
				wait_len = final_q;
			end else begin
				wait_len = long_q;
			end
		end else if (rs_q) begin
			wait_len = short_q;
		end else if (byte_q == ClearByte) begin
			wait_len = clear_q;
		end else if (byte_q[7]) begin
			wait_len = short_q;
		end else begin
			wait_len = long_q;
		end
	end

	// Next state of the sequencer for the item at the head of the queue.
	always_comb begin
		phase_d = phase_q;
		step_d  = step_q;
		cnt_d   = cnt_q;
		byte_d  = byte_q;
		rs_d    = rs_q;
		low_d   = low_q;
		acc_d   = 1'b0;
		if (pop) begin
			if (pop_item.is_tick) begin
				case (phase_q)
					PH_PULSE: begin
						cnt_d = cnt_q - CntW'(1);
						if (cnt_q == CntW'(1)) begin
							if (!low_q && step_q != StepWake) begin
								low_d   = 1'b1;
								phase_d = PH_GAP;
							end else begin
								phase_d = PH_WAIT;
								cnt_d   = load_count(wait_len);
							end
						end
					end
					PH_GAP: begin
						phase_d = PH_PULSE;
						cnt_d   = load_count({8'd0, pulse_q});
					end
					PH_WAIT: begin
						cnt_d = cnt_q - CntW'(1);
						if (cnt_q == CntW'(1)) begin
							if (step_q inside {[StepWake:StepClear]}) begin
								step_d  = step_q + 3'd1;
								byte_d  = init_byte(step_d, fs_q, dc_q, em_q);
								rs_d    = 1'b0;
								low_d   = 1'b0;
								phase_d = PH_PULSE;
								cnt_d   = load_count({8'd0, pulse_q});
							end else begin
								step_d  = StepNone;
								phase_d = PH_IDLE;
							end
						end
					end
					default: ;
				endcase
			end else if (phase_q == PH_IDLE) begin
				acc_d   = 1'b1;
				step_d  = pop_item.start_init ? StepWake : StepNone;
				byte_d  = pop_item.start_byte;
				rs_d    = pop_item.start_rs;
				low_d   = 1'b0;
				phase_d = PH_PULSE;
				cnt_d   = load_count({8'd0, pulse_q});
			end
		end
	end

	// Pin levels that follow from the next state.
	always_comb begin
		en_d   = (phase_d == PH_PULSE);
		busy_d = (phase_d != PH_IDLE);
		nib_d  = low_d ? byte_d[3:0] : byte_d[7:4];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			step_q      <= StepNone;
			cnt_q       <= '0;
			byte_q      <= '0;
			rs_q        <= 1'b0;
			low_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			step_q  <= step_d;
			cnt_q   <= cnt_d;
			byte_q  <= byte_d;
			rs_q    <= rs_d;
			low_q   <= low_d;
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			rs_pin_q   <= rs_d;
			en_pin_q   <= en_d;
			nib_q      <= nib_d;
			busy_pin_q <= busy_d;
			acc_pin_q  <= acc_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign rs_pin      = rs_pin_q;
	assign enable_pin  = en_pin_q;
	assign data_nibble = nib_q;
	assign busy_res    = busy_pin_q;
	assign accepted    = acc_pin_q;

	a_idle_no_init: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_IDLE) |-> (step_q == StepNone)) else $error("init step left while idle");

	a_busy_count: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PULSE || phase_q == PH_WAIT) |-> (cnt_q != '0))
		else $error("tick counter empty in a counting phase");

	a_acc_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && acc_pin_q) |-> (busy_pin_q && en_pin_q))
		else $error("accepted beat does not show a started write");

	a_pop_result: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> out_valid_q) else $error("popped item gave no result beat");

endmodule

@@ src/char_lcd_nibble_write_sequencer_core.sv @@
// Top level of the character LCD 4-bit write sequencer: front end, queue and back end.
//
// Usage: each input beat carries an operation and a data byte. Operation tick advances
// the write timing by one microsecond; instruction and character writes and initialize
// start a sequence when the sequencer is idle and are rejected (accepted low) when busy.
// Every input beat yields exactly one result beat with the pin levels after that beat
// (rs_pin, rw_pin, enable_pin, data_nibble), busy_res and accepted.
// A result beat is registered in the front end when its input beat is accepted, then
// written into the two-entry queue and from there into the result register. Throughput
// is one beat per cycle while the result receiver does not stall, set by the update of
// the sequencer state in the back end for each popped item.
// When the result receiver stalls, the result register holds, the queue fills and the
// front end then deasserts in_ready; no beat is lost or repeated.
// Reset clears the sequencer to idle with all latches zero and loads the configuration
// registers with their default timing and initialisation words. Configuration is written
// through cfg_wen, cfg_index and cfg_data without wait states.
module char_lcd_nibble_write_sequencer_core import lcdseq_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wen,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [CfgW-1:0]    cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         operation,
	input  logic [7:0]         data_byte,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               rs_pin,
	output logic               rw_pin,
	output logic               enable_pin,
	output logic [3:0]         data_nibble,
	output logic               busy_res,
	output logic               accepted
);

	logic  push_valid;
	logic  push_ready;
	item_t push_item;
	logic  pop_valid;
	logic  pop_ready;
	item_t pop_item;

	lcdseq_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.operation  (operation),
		.data_byte  (data_byte),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	lcdseq_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	lcdseq_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wen     (cfg_wen),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.pop_valid   (pop_valid),
		.pop_ready   (pop_ready),
		.pop_item    (pop_item),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.rs_pin      (rs_pin),
		.enable_pin  (enable_pin),
		.data_nibble (data_nibble),
		.busy_res    (busy_res),
		.accepted    (accepted)
	);

	assign rw_pin = 1'b0;

endmodule

@@ bench/lcd_pin_checker.sv @@
// Checker for the LCD write sequencer: predicts every result beat and compares it with the block.
module lcd_pin_checker import lcdseq_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wen,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [CfgW-1:0]    cfg_data,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [1:0]         operation,
	input  logic [7:0]         data_byte,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic               rs_pin,
	input  logic               rw_pin,
	input  logic               enable_pin,
	input  logic [3:0]         data_nibble,
	input  logic               busy_res,
	input  logic               accepted,
	output int                 fail_count,
	output int                 pending_beats
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] StepFuncFirst  = 3'd2;
	localparam logic [2:0] StepFuncSecond = 3'd3;
	localparam logic [2:0] StepDisplay    = 3'd4;

	typedef struct packed {
		logic       rs;
		logic       rw;
		logic       en;
		logic [3:0] nibble;
		logic       busy;
		logic       acc;
	} lcd_pins_t;

	logic [7:0]  pulse_len;
	logic [15:0] short_wait;
	logic [15:0] long_wait;
	logic [15:0] clear_wait;
	logic [15:0] final_wait;
	logic [7:0]  func_word;
	logic [7:0]  display_word;
	logic [7:0]  entry_word;

	phase_t      seq_phase;
	logic [2:0]  init_step;
	logic [15:0] ticks_left;
	logic [7:0]  byte_q;
	logic        rs_q;
	logic        low_half;

	lcd_pins_t   pins_due [$];
	lcd_pins_t   seen;
	lcd_pins_t   want;

	function automatic logic [15:0] load_value(input logic [15:0] v);
		return (v == 16'd0) ? 16'd1 : v;
	endfunction

	function automatic logic [7:0] init_word(input logic [2:0] step);
		if (step == StepWake) begin
			return WakeByte;
		end
		if (step == StepFuncFirst || step == StepFuncSecond) begin
			return func_word;
		end
		if (step == StepDisplay) begin
			return display_word;
		end
		if (step == StepClear) begin
			return ClearByte;
		end
		return entry_word;
	endfunction

	function automatic void launch_byte(input logic [7:0] b, input logic rs);
		byte_q = b;
		rs_q = rs;
		low_half = 1'b0;
		seq_phase = PH_PULSE;
		ticks_left = load_value({8'd0, pulse_len});
	endfunction

	function automatic logic [15:0] wait_for_byte();
		if (init_step != StepNone) begin
			if (init_step == StepClear) begin
				return clear_wait;
			end
			if (init_step >= StepEntry) begin
				return final_wait;
			end
			return long_wait;
		end
		if (rs_q) begin
			return short_wait;
		end
		if (byte_q == ClearByte) begin
			return clear_wait;
		end
		if (byte_q[7]) begin
			return short_wait;
		end
		return long_wait;
	endfunction

	function automatic void advance_one_tick();
		case (seq_phase)
			PH_PULSE: begin
				ticks_left = ticks_left - 16'd1;
				if (ticks_left == 16'd0) begin
					if (!low_half && init_step != StepWake) begin
						low_half = 1'b1;
						seq_phase = PH_GAP;
					end else begin
						seq_phase = PH_WAIT;
						ticks_left = load_value(wait_for_byte());
					end
				end
			end
			PH_GAP: begin
				seq_phase = PH_PULSE;
				ticks_left = load_value({8'd0, pulse_len});
			end
			PH_WAIT: begin
				ticks_left = ticks_left - 16'd1;
				if (ticks_left == 16'd0) begin
					if (init_step >= StepWake && init_step <= StepClear) begin
						init_step = init_step + 3'd1;
						launch_byte(init_word(init_step), 1'b0);
					end else begin
						init_step = StepNone;
						seq_phase = PH_IDLE;
					end
				end
			end
			default: begin
			end
		endcase
	endfunction

	function automatic lcd_pins_t apply_beat(input op_t op, input logic [7:0] db);
		lcd_pins_t p;
		logic      acc;
		acc = 1'b0;
		if (op == OP_TICK) begin
			advance_one_tick();
		end else if (seq_phase == PH_IDLE) begin
			acc = 1'b1;
			case (op)
				OP_INSTR: begin
					init_step = StepNone;
					launch_byte(db, 1'b0);
				end
				OP_CHAR: begin
					init_step = StepNone;
					launch_byte(db, 1'b1);
				end
				default: begin
					init_step = StepWake;
					launch_byte(init_word(StepWake), 1'b0);
				end
			endcase
		end
		p.rs = rs_q;
		p.rw = 1'b0;
		p.en = (seq_phase == PH_PULSE);
		p.nibble = low_half ? byte_q[3:0] : byte_q[7:4];
		p.busy = (seq_phase != PH_IDLE);
		p.acc = acc;
		return p;
	endfunction

	function automatic void store_reg(input cfg_idx_t idx, input logic [CfgW-1:0] v);
		case (idx)
			CFG_ENABLE_PULSE:    pulse_len = v[7:0];
			CFG_SHORT_WAIT:      short_wait = v;
			CFG_LONG_WAIT:       long_wait = v;
			CFG_CLEAR_WAIT:      clear_wait = v;
			CFG_INIT_FINAL_WAIT: final_wait = v;
			CFG_FUNCTION_SET:    func_word = v[7:0];
			CFG_DISPLAY_CONTROL: display_word = v[7:0];
			default:             entry_word = v[7:0];
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_len = RstEnablePulse;
			short_wait = RstShortWait;
			long_wait = RstLongWait;
			clear_wait = RstClearWait;
			final_wait = RstInitFinal;
			func_word = RstFunctionSet;
			display_word = RstDisplayCtrl;
			entry_word = RstEntryMode;
			seq_phase = PH_IDLE;
			init_step = StepNone;
			ticks_left = '0;
			byte_q = '0;
			rs_q = 1'b0;
			low_half = 1'b0;
			pins_due.delete();
			fail_count = 0;
			pending_beats <= 0;
		end else begin
			if (in_valid && in_ready) begin
				pins_due.push_back(apply_beat(op_t'(operation), data_byte));
			end
			if (out_valid && out_ready) begin
				seen = {rs_pin, rw_pin, enable_pin, data_nibble, busy_res, accepted};
				if (pins_due.size() == 0) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("unexpected result beat: rs %0b rw %0b e %0b d %h busy %0b acc %0b",
							seen.rs, seen.rw, seen.en, seen.nibble, seen.busy, seen.acc);
					end
				end else begin
					want = pins_due.pop_front();
					if (seen !== want) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("result beat mismatch: expected rs %0b rw %0b e %0b d %h busy %0b acc %0b",
								want.rs, want.rw, want.en, want.nibble, want.busy, want.acc);
							$display("                      actual   rs %0b rw %0b e %0b d %h busy %0b acc %0b",
								seen.rs, seen.rw, seen.en, seen.nibble, seen.busy, seen.acc);
						end
					end
				end
			end
			if (cfg_wen) begin
				store_reg(cfg_idx_t'(cfg_index), cfg_data);
			end
			pending_beats <= pins_due.size();
		end
	end

endmodule

@@ bench/char_lcd_nibble_write_sequencer_core_tb.sv @@
// Testbench top for the LCD write sequencer: clock, reset, stimulus and the final verdict.
module char_lcd_nibble_write_sequencer_core_tb import lcdseq_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CycleLimit = 1_000_000;
	localparam int ItemTarget = 1950;
	localparam int TailItems  = 848;
	localparam int PhaseCount = 6;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_wen = 1'b0;
	logic [CfgIdxW-1:0] cfg_index = '0;
	logic [CfgW-1:0]    cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [1:0]         operation = '0;
	logic [7:0]         data_byte = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic               rs_pin;
	logic               rw_pin;
	logic               enable_pin;
	logic [3:0]         data_nibble;
	logic               busy_res;
	logic               accepted;

	int          fail_count;
	int          pending_beats;
	int          send_idle_pct = 22;
	int          recv_idle_pct = 83;
	int          items_sent = 0;
	int          cycles = 0;
	logic [15:0] regs_now [8];

	char_lcd_nibble_write_sequencer_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wen     (cfg_wen),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.operation   (operation),
		.data_byte   (data_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.rs_pin      (rs_pin),
		.rw_pin      (rw_pin),
		.enable_pin  (enable_pin),
		.data_nibble (data_nibble),
		.busy_res    (busy_res),
		.accepted    (accepted)
	);

	lcd_pin_checker chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wen       (cfg_wen),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.operation     (operation),
		.data_byte     (data_byte),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.rs_pin        (rs_pin),
		.rw_pin        (rw_pin),
		.enable_pin    (enable_pin),
		.data_nibble   (data_nibble),
		.busy_res      (busy_res),
		.accepted      (accepted),
		.fail_count    (fail_count),
		.pending_beats (pending_beats)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CycleLimit) begin
			$display("char_lcd_nibble_write_sequencer_core test failed");
			$finish;
		end
	end

	function automatic int count_ticks(input logic [15:0] v);
		return (v == 16'd0) ? 1 : int'(v);
	endfunction

	// Ticks needed to bring the sequencer back to idle after the given command.
	function automatic int sequence_ticks(input op_t op, input logic [7:0] db);
		int e;
		int l;
		int w;
		e = count_ticks({8'd0, regs_now[CFG_ENABLE_PULSE][7:0]});
		l = count_ticks(regs_now[CFG_LONG_WAIT]);
		case (op)
			OP_CHAR: begin
				w = count_ticks(regs_now[CFG_SHORT_WAIT]);
			end
			OP_INSTR: begin
				if (db == ClearByte) begin
					w = count_ticks(regs_now[CFG_CLEAR_WAIT]);
				end else if (db[7]) begin
					w = count_ticks(regs_now[CFG_SHORT_WAIT]);
				end else begin
					w = l;
				end
			end
			OP_INIT: begin
				return e + l + 3 * (2 * e + 1 + l)
					+ (2 * e + 1 + count_ticks(regs_now[CFG_CLEAR_WAIT]))
					+ (2 * e + 1 + count_ticks(regs_now[CFG_INIT_FINAL_WAIT]));
			end
			default: begin
				return 0;
			end
		endcase
		return 2 * e + 1 + w;
	endfunction

	task automatic send_item(input op_t op, input logic [7:0] db);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		data_byte <= db;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		items_sent++;
	endtask

	task automatic send_ticks(input int n);
		for (int k = 0; k < n; k++) begin
			send_item(OP_TICK, 8'($urandom_range(255)));
		end
	endtask

	// Waits for every outstanding result beat, then writes all eight registers.
	task automatic apply_settings(input logic [15:0] pulse, input logic [15:0] short_w,
			input logic [15:0] long_w, input logic [15:0] clear_w, input logic [15:0] final_w,
			input logic [15:0] func_w, input logic [15:0] disp_w, input logic [15:0] entry_w);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_beats != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
		regs_now[CFG_ENABLE_PULSE] = pulse;
		regs_now[CFG_SHORT_WAIT] = short_w;
		regs_now[CFG_LONG_WAIT] = long_w;
		regs_now[CFG_CLEAR_WAIT] = clear_w;
		regs_now[CFG_INIT_FINAL_WAIT] = final_w;
		regs_now[CFG_FUNCTION_SET] = func_w;
		regs_now[CFG_DISPLAY_CONTROL] = disp_w;
		regs_now[CFG_ENTRY_MODE] = entry_w;
		for (int i = 0; i < 8; i++) begin
			cfg_wen <= 1'b1;
			cfg_index <= cfg_idx_t'(i);
			cfg_data <= regs_now[i];
			@(posedge clk);
		end
		cfg_wen <= 1'b0;
	endtask

	// Mostly a complete command followed by its ticks; some sequences are cut short or
	// overrun, some carry stray commands, and some are plain noise.
	task automatic random_sequence();
		op_t        op;
		logic [7:0] db;
		int         n;
		int         r;
		r = $urandom_range(99);
		if (r < 15) begin
			repeat ($urandom_range(1, 6)) begin
				send_item(op_t'($urandom_range(3)), 8'($urandom_range(255)));
			end
			return;
		end
		op = (r < 55) ? OP_CHAR : (r < 92) ? OP_INSTR : OP_INIT;
		case ($urandom_range(3))
			0: db = (op == OP_INSTR) ? ClearByte : 8'($urandom_range(255));
			1: db = 8'h80 | 8'($urandom_range(127));
			2: db = 8'($urandom_range(127));
			default: db = 8'($urandom_range(255));
		endcase
		send_item(op, db);
		n = sequence_ticks(op, db);
		r = $urandom_range(9);
		if (r == 0) begin
			n = $urandom_range(n);
		end else if (r < 3) begin
			n = n + $urandom_range(1, 4);
		end
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(19) == 0) begin
				send_item(op_t'($urandom_range(1, 3)), 8'($urandom_range(255)));
			end
			send_item(OP_TICK, 8'($urandom_range(255)));
		end
	endtask

	initial begin
		regs_now[CFG_ENABLE_PULSE] = {8'd0, RstEnablePulse};
		regs_now[CFG_SHORT_WAIT] = RstShortWait;
		regs_now[CFG_LONG_WAIT] = RstLongWait;
		regs_now[CFG_CLEAR_WAIT] = RstClearWait;
		regs_now[CFG_INIT_FINAL_WAIT] = RstInitFinal;
		regs_now[CFG_FUNCTION_SET] = {8'd0, RstFunctionSet};
		regs_now[CFG_DISPLAY_CONTROL] = {8'd0, RstDisplayCtrl};
		regs_now[CFG_ENTRY_MODE] = {8'd0, RstEntryMode};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Timing straight out of reset.
		send_item(OP_CHAR, 8'h41);
		send_ticks(sequence_ticks(OP_CHAR, 8'h41));
		send_item(OP_INSTR, 8'h28);
		send_ticks(sequence_ticks(OP_INSTR, 8'h28));

		// Zero registers count as one tick; upper data bits of byte registers are dropped.
		apply_settings(16'hFF00, 16'd0, 16'd0, 16'd0, 16'd0, 16'h12FF, 16'h3400, 16'h5680);
		send_item(OP_TICK, 8'h00);
		send_item(OP_INIT, 8'hFF);
		send_item(OP_CHAR, 8'hFF);
		send_ticks(sequence_ticks(OP_INIT, 8'h00));
		send_item(OP_INSTR, ClearByte);
		send_item(OP_INIT, 8'h00);
		send_ticks(sequence_ticks(OP_INSTR, ClearByte));
		send_item(OP_INSTR, 8'h80);
		send_item(OP_TICK, 8'hFF);
		send_item(OP_INSTR, 8'h7F);
		send_ticks(sequence_ticks(OP_INSTR, 8'h80));

		for (int ph = 0; ph < PhaseCount; ph++) begin
			if (ph < 2) begin
				send_idle_pct = 22;
				recv_idle_pct = 83;
			end else if (ph < 4) begin
				send_idle_pct = 83;
				recv_idle_pct = 22;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			if (ph == 0) begin
				apply_settings(16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'h0000, 16'h00FF, 16'h0001);
			end else begin
				apply_settings({8'($urandom_range(255)), 8'($urandom_range(5))},
					16'($urandom_range(24)), 16'($urandom_range(24)),
					16'($urandom_range(24)), 16'($urandom_range(24)),
					16'($urandom_range(65535)), 16'($urandom_range(65535)),
					16'($urandom_range(65535)));
			end
			while (items_sent < (ItemTarget - TailItems) * (ph + 1) / PhaseCount) begin
				random_sequence();
			end
		end

		// Largest register values. After 300 ticks the low nibble strobe has 211 ticks left;
		// the clear wait is then shortened and takes effect when the wait is loaded.
		apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h00FF, 16'hFF00,
			16'hFFFF);
		send_item(OP_INSTR, ClearByte);
		send_ticks(300);
		apply_settings(16'h00FF, 16'hFFFF, 16'hFFFF, 16'd3, 16'hFFFF, 16'h00FF, 16'hFF00,
			16'hFFFF);
		send_ticks(211 + 3 + 2);

		// Initialisation with the power-on values written back explicitly.
		apply_settings({8'd0, RstEnablePulse}, RstShortWait, RstLongWait, RstClearWait,
			RstInitFinal, {8'd0, RstFunctionSet}, {8'd0, RstDisplayCtrl},
			{8'd0, RstEntryMode});
		send_item(OP_INIT, 8'($urandom_range(255)));
		send_ticks(330);

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_beats != 0) begin
			@(posedge clk);
		end
		repeat (10) @(posedge clk);
		if (fail_count == 0) begin
			$display("char_lcd_nibble_write_sequencer_core test passed");
		end else begin
			$display("char_lcd_nibble_write_sequencer_core test failed");
		end
		$finish;
	end

endmodule
